// ===== sv/lps_pkg.sv =====
// types, constants and frame tables shared by the led pattern sequencer
package lps_pkg;

    localparam int DELAY_W    = 32;
    localparam int FRAME_W    = 4;
    localparam int MODE_W     = 3;
    localparam int LED_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DELAY_W-1:0] DELAY_MAX        = '1;
    localparam logic [DELAY_W-1:0] RST_INIT_DELAY   = DELAY_W'(150000000);
    localparam logic [DELAY_W-1:0] RST_DELAY_STEP   = DELAY_W'(5000000);
    localparam logic [DELAY_W-1:0] RST_MIN_DELAY    = DELAY_W'(1000000);

    // pattern modes, codes five to seven fall back to the sweep
    localparam logic [MODE_W-1:0] MODE_SWEEP = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CRASH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RACE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PLANE = 3'd4;

    localparam logic [FRAME_W-1:0] LEN_SWEEP = 4'd14;
    localparam logic [FRAME_W-1:0] LEN_CRASH = 4'd6;
    localparam logic [FRAME_W-1:0] LEN_RACE  = 4'd6;
    localparam logic [FRAME_W-1:0] LEN_BAR   = 4'd9;
    localparam logic [FRAME_W-1:0] LEN_PLANE = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_INIT_DELAY = 2'd1,
        CFG_DELAY_STEP = 2'd2,
        CFG_MIN_DELAY  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic restart;
        logic key_up;
        logic key_down;
    } t_req;

    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             frame_advanced;
        logic [31:0]      delay_now;
    } t_rsp;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [DELAY_W-1:0] tick;
        logic [DELAY_W-1:0] delay;
        logic               pend_up;
        logic               pend_down;
    } t_seq_state;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DELAY_W-1:0] init_delay;
        logic [DELAY_W-1:0] step;
        logic [DELAY_W-1:0] floor_delay;
    } t_seq_cfg;

    function automatic logic [FRAME_W-1:0] seq_len(input logic [MODE_W-1:0] mode);
        logic [FRAME_W-1:0] len;
        case (mode)
            MODE_CRASH: len = LEN_CRASH;
            MODE_RACE:  len = LEN_RACE;
            MODE_BAR:   len = LEN_BAR;
            MODE_PLANE: len = LEN_PLANE;
            default:    len = LEN_SWEEP;
        endcase
        return len;
    endfunction

    // frame pattern, zero for a frame past the end of the sequence
    function automatic logic [LED_W-1:0] frame_leds(input logic [MODE_W-1:0]  mode,
                                                    input logic [FRAME_W-1:0] frame);
        logic [LED_W-1:0] pat;
        pat = '0;
        case (mode)
            MODE_CRASH: begin
                case (frame)
                    4'd0:    pat = 8'h81;
                    4'd1:    pat = 8'h42;
                    4'd2:    pat = 8'h24;
                    4'd3:    pat = 8'h18;
                    4'd4:    pat = 8'h24;
                    4'd5:    pat = 8'h42;
                    default: pat = 8'h00;
                endcase
            end
            MODE_RACE: begin
                case (frame)
                    4'd0:    pat = 8'hA0;
                    4'd1:    pat = 8'h30;
                    4'd2:    pat = 8'h08;
                    4'd3:    pat = 8'h06;
                    4'd4:    pat = 8'h03;
                    4'd5:    pat = 8'h01;
                    default: pat = 8'h00;
                endcase
            end
            MODE_BAR: begin
                case (frame)
                    4'd0:    pat = 8'h00;
                    4'd1:    pat = 8'h80;
                    4'd2:    pat = 8'hC0;
                    4'd3:    pat = 8'hE0;
                    4'd4:    pat = 8'hF0;
                    4'd5:    pat = 8'hF8;
                    4'd6:    pat = 8'hFC;
                    4'd7:    pat = 8'hFE;
                    4'd8:    pat = 8'hFF;
                    default: pat = 8'h00;
                endcase
            end
            MODE_PLANE: begin
                case (frame)
                    4'd0:    pat = 8'h80;
                    4'd1:    pat = 8'h20;
                    4'd2:    pat = 8'h08;
                    4'd3:    pat = 8'h02;
                    default: pat = 8'h00;
                endcase
            end
            default: begin
                case (frame)
                    4'd0:    pat = 8'h80;
                    4'd1:    pat = 8'h40;
                    4'd2:    pat = 8'h20;
                    4'd3:    pat = 8'h10;
                    4'd4:    pat = 8'h08;
                    4'd5:    pat = 8'h04;
                    4'd6:    pat = 8'h02;
                    4'd7:    pat = 8'h01;
                    4'd8:    pat = 8'h02;
                    4'd9:    pat = 8'h04;
                    4'd10:   pat = 8'h08;
                    4'd11:   pat = 8'h10;
                    4'd12:   pat = 8'h20;
                    4'd13:   pat = 8'h40;
                    default: pat = 8'h00;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/led_pattern_sequencer_core.sv =====
// top level of the eight-led pattern sequencer with its register file and output skid
// Each request is one tick of the frame timer and yields exactly one result: the led
// pattern, a frame-advanced flag and the current hold time. A request is taken every
// cycle and its result is registered; the tick, frame and delay update is a loop through
// the sequencer state registers, so the sustained rate is one request per cycle while the
// sink keeps up. A two-deep output (result register plus skid register) keeps input ready
// high for one more request while a result is held back by the sink. Configuration writes
// take effect at once and are meant to be made while the block is idle.
module led_pattern_sequencer_core
    import lps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_req                  i_req,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_rsp                  o_rsp
);

    // configuration registers
    logic [MODE_W-1:0]  r_mode;
    logic [DELAY_W-1:0] r_init_delay;
    logic [DELAY_W-1:0] r_delay_step;
    logic [DELAY_W-1:0] r_min_delay;

    // sequencer state
    t_seq_state r_state;
    t_seq_state n_state;
    t_seq_cfg   seq_cfg;
    t_rsp       step_rsp;

    // output register and skid stage
    logic r_out_valid;
    logic n_out_valid;
    t_rsp r_out;
    t_rsp n_out;
    logic r_skid_valid;
    logic n_skid_valid;
    t_rsp r_skid;
    t_rsp n_skid;

    logic accept;
    logic pop;

    assign seq_cfg.mode        = r_mode;
    assign seq_cfg.init_delay  = r_init_delay;
    assign seq_cfg.step        = r_delay_step;
    assign seq_cfg.floor_delay = r_min_delay;

    // ready only drops once the skid register is holding a result
    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign pop     = r_out_valid && i_ready;

    lps_step u_step (
        .i_state (r_state),
        .i_cfg   (seq_cfg),
        .i_req   (i_req),
        .o_state (n_state),
        .o_rsp   (step_rsp)
    );

    // register file, every two-bit index selects one of the four registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SWEEP;
            r_init_delay <= RST_INIT_DELAY;
            r_delay_step <= RST_DELAY_STEP;
            r_min_delay  <= RST_MIN_DELAY;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:       r_mode       <= i_cfg_data[MODE_W-1:0];
                CFG_INIT_DELAY: r_init_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_DELAY_STEP: r_delay_step <= i_cfg_data[DELAY_W-1:0];
                CFG_MIN_DELAY:  r_min_delay  <= i_cfg_data[DELAY_W-1:0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    // sequencer state only moves on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.frame     <= '0;
            r_state.tick      <= '0;
            r_state.delay     <= RST_INIT_DELAY;
            r_state.pend_up   <= 1'b0;
            r_state.pend_down <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // output queue: drain first, then place the new result in the first free slot
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (accept) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = step_rsp;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = step_rsp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // skid stage is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    // a restart request leaves frame zero and a cleared tick counter
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.restart) |=> (r_state.frame == '0) && (r_state.tick == '0)
            && !r_state.pend_up && !r_state.pend_down)
        else $error("restart did not clear sequencer state");

    // frame index never runs past the longest sequence
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.frame < LEN_SWEEP)
        else $error("frame index beyond longest sequence");

    // an advancing tick always leaves the tick counter at zero
    a_advance_zero_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && step_rsp.frame_advanced) |=> (r_state.tick == '0))
        else $error("frame advanced without clearing the tick counter");

endmodule

// ===== sv/lps_step.sv =====
// next-state and result logic for one timer tick
module lps_step
    import lps_pkg::*;
(
    input  t_seq_state i_state,
    input  t_seq_cfg   i_cfg,
    input  t_req       i_req,
    output t_seq_state o_state,
    output t_rsp       o_rsp
);

    logic [FRAME_W-1:0] len;
    logic               pu;
    logic               pd;
    logic [DELAY_W-1:0] tick_lo;
    logic               boundary;
    logic [FRAME_W:0]   frame_inc;
    logic [DELAY_W:0]   sum;
    logic [DELAY_W:0]   diff;
    logic [DELAY_W-1:0] max_minus;
    logic [DELAY_W-1:0] adj_delay;
    logic               advanced;
    t_seq_state         nxt;

    assign len       = seq_len(i_cfg.mode);
    assign pu        = i_state.pend_up | i_req.key_up;
    assign pd        = i_state.pend_down | i_req.key_down;
    assign tick_lo   = i_state.tick + {{(DELAY_W-1){1'b0}}, 1'b1};
    // zero delay acts like one: a wrapped count also ends the frame
    assign boundary  = (tick_lo >= i_state.delay) || (tick_lo == '0);
    assign frame_inc = {1'b0, i_state.frame} + {{FRAME_W{1'b0}}, 1'b1};

    // up and down outcomes worked out side by side
    assign sum       = {1'b0, i_state.delay} + {1'b0, i_cfg.step};
    assign diff      = {1'b0, i_state.delay} - {1'b0, i_cfg.step};
    assign max_minus = DELAY_MAX - i_cfg.step;

    always_comb begin
        adj_delay = i_state.delay;
        priority if (pu && pd) begin
            // up then down: unsaturated sum minus step is the old delay
            if (sum[DELAY_W]) begin
                adj_delay = (max_minus > i_cfg.floor_delay) ? max_minus : DELAY_MAX;
            end else begin
                adj_delay = (i_state.delay > i_cfg.floor_delay) ? i_state.delay
                                                                : sum[DELAY_W-1:0];
            end
        end else if (pu) begin
            adj_delay = sum[DELAY_W] ? DELAY_MAX : sum[DELAY_W-1:0];
        end else if (pd) begin
            if (!diff[DELAY_W] && (diff[DELAY_W-1:0] > i_cfg.floor_delay)) begin
                adj_delay = diff[DELAY_W-1:0];
            end
        end else begin
            adj_delay = i_state.delay;
        end
    end

    always_comb begin
        nxt      = i_state;
        advanced = 1'b0;
        if (i_req.restart) begin
            nxt.frame     = '0;
            nxt.tick      = '0;
            nxt.delay     = i_cfg.init_delay;
            nxt.pend_up   = 1'b0;
            nxt.pend_down = 1'b0;
        end else if (boundary) begin
            advanced      = 1'b1;
            nxt.tick      = '0;
            nxt.frame     = (frame_inc >= {1'b0, len}) ? '0 : frame_inc[FRAME_W-1:0];
            nxt.delay     = adj_delay;
            nxt.pend_up   = 1'b0;
            nxt.pend_down = 1'b0;
        end else begin
            nxt.tick      = tick_lo;
            nxt.pend_up   = pu;
            nxt.pend_down = pd;
        end
    end

    assign o_state              = nxt;
    assign o_rsp.leds           = frame_leds(i_cfg.mode, nxt.frame);
    assign o_rsp.frame_advanced = advanced;
    assign o_rsp.delay_now      = nxt.delay[31:0];

endmodule
